// File: rtl/length_prefixed_message_fifo_defines.svh
// ----------------------------------------------------------------------------
// Length-prefixed message FIFO assertion macros
// Concurrent assertion wrappers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_DEFINES_SVH

`ifndef SYNTH
`define LPMF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lpmf assertion failed");
`define LPMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpmf assertion failed");
`else
`define LPMF_ASSERT(lbl, clk, rst, prop)
`define LPMF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/lpmf_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed message FIFO package
// Shared constants, status codes and the command type.
// ----------------------------------------------------------------------------
package lpmf_pkg;

  localparam int LPMF_RING_DEPTH = 1024;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_BAD   = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_UNEXPECTED = 3'd3;
  localparam logic [2:0] ST_DROPPED    = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] length;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: rtl/lpmf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lpmf_front.sv
// ----------------------------------------------------------------------------
// Length-prefixed message FIFO front end
// Accept input items, classify them into commands and queue them.
// ----------------------------------------------------------------------------
module lpmf_front import lpmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] length,
  input  logic [7:0] data_in,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.length = length;
    cmd_in.data   = data_in;
    case (operation)
      OP_START: cmd_in.kind = CMD_START;
      OP_PUSH:  cmd_in.kind = CMD_PUSH;
      OP_POP:   cmd_in.kind = CMD_POP;
      default:  cmd_in.kind = CMD_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= cmd_in;
        wr_ptr        <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: rtl/lpmf_back.sv
// ----------------------------------------------------------------------------
// Length-prefixed message FIFO back end
// Execute queued commands against the byte ring and register results.
// ----------------------------------------------------------------------------
`include "length_prefixed_message_fifo_defines.svh"

module lpmf_back import lpmf_pkg::*; #(
  parameter int RING_DEPTH = LPMF_RING_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] data_out,
  output logic       last,
  output logic       zero_length,
  output logic       has_next
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int UW = (PW + 1 > 9) ? PW + 1 : 9;
  localparam int SW = ((PW > 8) ? PW : 8) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state;
  logic [PW-1:0] rp;
  logic [PW-1:0] cp;
  logic [PW-1:0] wp;
  logic [7:0]    wrem;
  logic          wdrop;
  logic [7:0]    rrem;
  logic          in_msg;
  logic [2:0]    res_status;
  logic [7:0]    res_data;
  logic          res_last;
  logic          res_zlen;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic [PW-1:0] rp_inc;
  logic [PW-1:0] wp_inc;
  logic [UW-1:0] used;
  logic [UW-1:0] avail;
  logic          fit;
  logic          busy_fill;
  logic [SW-1:0] adv_sum;
  logic [SW-1:0] adv;
  logic [PW-1:0] next_hdr;
  logic          pending;
  logic          out_free;

  lpmf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rp_inc = (rp == PW'(RING_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign wp_inc = (wp == PW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign used   = (wp >= rp) ? UW'(wp) - UW'(rp) : UW'(RING_DEPTH) - UW'(rp) + UW'(wp);
  assign avail  = UW'(RING_DEPTH - 1) - used;
  assign fit    = (UW'(q_cmd.length) + UW'(1)) <= avail;
  assign busy_fill = (wrem != 8'd0) && !wdrop;

  assign adv_sum  = SW'(rp) + SW'(rrem);
  assign adv      = (adv_sum >= SW'(RING_DEPTH)) ? adv_sum - SW'(RING_DEPTH) : adv_sum;
  assign next_hdr = in_msg ? adv[PW-1:0] : rp;
  assign pending  = (next_hdr != cp);

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp;
    wr_data = q_cmd.length;
    rd_en   = 1'b0;
    rd_addr = rp;
    if (state == S_IDLE && q_valid) begin
      case (q_cmd.kind)
        CMD_START: wr_en = !busy_fill && fit;
        CMD_PUSH: begin
          wr_en   = busy_fill;
          wr_data = q_cmd.data;
        end
        CMD_POP: rd_en = in_msg || (rp != cp);
        default: ;
      endcase
    end else if (state == S_HDR) begin
      rd_en = (rd_data != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      cp        <= '0;
      wp        <= '0;
      wrem      <= 8'd0;
      wdrop     <= 1'b0;
      rrem      <= 8'd0;
      in_msg    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            res_data   <= 8'd0;
            res_last   <= 1'b0;
            res_zlen   <= 1'b0;
            res_status <= ST_UNEXPECTED;
            state      <= S_FIN;
            case (q_cmd.kind)
              CMD_START: begin
                if (!busy_fill) begin
                  wdrop <= 1'b0;
                  wrem  <= 8'd0;
                  if (fit) begin
                    wp         <= wp_inc;
                    res_status <= ST_OK;
                    if (q_cmd.length == 8'd0) begin
                      cp <= wp_inc;
                    end else begin
                      wrem <= q_cmd.length;
                    end
                  end else begin
                    res_status <= ST_FULL;
                    wrem       <= q_cmd.length;
                    wdrop      <= (q_cmd.length != 8'd0);
                  end
                end
              end
              CMD_PUSH: begin
                if (wrem != 8'd0) begin
                  wrem <= wrem - 8'd1;
                  if (wdrop) begin
                    res_status <= ST_DROPPED;
                    if (wrem == 8'd1) begin
                      wdrop <= 1'b0;
                    end
                  end else begin
                    res_status <= ST_OK;
                    wp         <= wp_inc;
                    if (wrem == 8'd1) begin
                      cp <= wp_inc;
                    end
                  end
                end
              end
              CMD_POP: begin
                if (in_msg) begin
                  res_status <= ST_OK;
                  rp         <= rp_inc;
                  rrem       <= rrem - 8'd1;
                  if (rrem == 8'd1) begin
                    in_msg   <= 1'b0;
                    res_last <= 1'b1;
                  end
                  state <= S_DATA;
                end else if (rp == cp) begin
                  res_status <= ST_EMPTY;
                end else begin
                  res_status <= ST_OK;
                  rp         <= rp_inc;
                  state      <= S_HDR;
                end
              end
              default: ;
            endcase
          end
        end
        S_HDR: begin
          if (rd_data == 8'd0) begin
            res_zlen <= 1'b1;
            res_last <= 1'b1;
            state    <= S_FIN;
          end else begin
            rp       <= rp_inc;
            rrem     <= rd_data - 8'd1;
            in_msg   <= (rd_data != 8'd1);
            res_last <= (rd_data == 8'd1);
            state    <= S_DATA;
          end
        end
        S_DATA: begin
          res_data <= rd_data;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            data_out    <= res_data;
            last        <= res_last;
            zero_length <= res_zlen;
            has_next    <= pending;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LPMF_ASSERT(a_write_idle, clk, rst, wr_en |-> (state == S_IDLE))
  `LPMF_ASSERT(a_drop_count, clk, rst, wdrop |-> (wrem != 8'd0))
  `LPMF_ASSERT(a_read_count, clk, rst, in_msg |-> (rrem != 8'd0))
  `LPMF_ASSERT_NEXT(a_one_result, clk, rst, (state == S_FIN) && out_free,
    out_valid && (state == S_IDLE))

endmodule

// File: rtl/length_prefixed_message_fifo.sv
// ----------------------------------------------------------------------------
// Length-prefixed message FIFO
// Byte ring of length-prefixed messages with start, push and pop items.
// ----------------------------------------------------------------------------
// Each item returns exactly one result. Starts, pushes, empty pops and
// unexpected items go straight to the engine's result state; a pop inside a
// message passes a data state, and one that opens a message passes a header
// state, then a data state if the length is nonzero, since ring RAM reads are
// registered. A two-entry command queue sits in front so input transfers keep
// flowing while a result waits at the output register. Reads of ring entries
// only ever hit committed bytes, so the ring needs no clearing after reset.
module length_prefixed_message_fifo import lpmf_pkg::*; #(
  parameter int RING_DEPTH = LPMF_RING_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] length,
  input  logic [7:0] data_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] data_out,
  output logic       last,
  output logic       zero_length,
  output logic       has_next
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  lpmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .length    (length),
    .data_in   (data_in),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  lpmf_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .data_out    (data_out),
    .last        (last),
    .zero_length (zero_length),
    .has_next    (has_next)
  );

endmodule
